>>> src/bsb_pkg.sv
`default_nettype none
package bsb_pkg;

   localparam int MAX_KNOTS   = 64;
   localparam int KNOT_AW     = $clog2(MAX_KNOTS);
   localparam int MAX_DEGREE  = 7;
   localparam int BASIS_DEPTH = 16;
   localparam int BASIS_AW    = $clog2(BASIS_DEPTH);
   localparam int DIV_STEPS   = 16;

   localparam logic [16:0] ONE_Q16 = 17'd65536;

   localparam logic [1:0] CMD_WR_KNOT  = 2'd0;
   localparam logic [1:0] CMD_WR_COEFF = 2'd1;
   localparam logic [1:0] CMD_EVAL     = 2'd2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_BELOW = 2'd1;
   localparam logic [1:0] STATUS_ACK   = 2'd2;

   localparam logic CSR_DEGREE    = 1'b0;
   localparam logic CSR_NUM_KNOTS = 1'b1;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [5:0]         table_index;
      logic signed [31:0] write_value;
      logic signed [31:0] x_value;
   } req_type;

   typedef struct packed {
      logic [5:0]         basis_index;
      logic [16:0]        basis_value;
      logic signed [31:0] spline_value;
      logic [1:0]         status;
      logic               last;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SRCH_RD,
      ST_SRCH_CMP,
      ST_ERR,
      ST_INIT,
      ST_TL,
      ST_TR,
      ST_PREP,
      ST_DIV,
      ST_MUL,
      ST_ACC,
      ST_LAST,
      ST_DOT_RD,
      ST_DOT_MUL,
      ST_DOT_OUT
   } state_type;

   function automatic logic [16:0] clamp_q16(input logic [34:0] nb);
      logic [34:0] sum;
      logic [18:0] v;
      sum = nb + 35'h8000;
      v   = sum[34:16];
      if (v > {2'b0, ONE_Q16}) begin
         return ONE_Q16;
      end
      return v[16:0];
   endfunction

   function automatic logic [KNOT_AW-1:0] knot_idx(input logic signed [8:0] idx,
                                                   input logic [6:0] n);
      logic [6:0] top;
      top = n - 7'd1;
      if (idx < 9'sd0) begin
         return '0;
      end
      if (idx > $signed({2'b0, top})) begin
         return top[KNOT_AW-1:0];
      end
      return idx[KNOT_AW-1:0];
   endfunction

endpackage
`default_nettype wire

>>> src/bspline_basis_evaluator.sv
// write item: acknowledge registered in the cycle after acceptance
// evaluate item: a knot read and a compare per knot for the span search, then per
// recurrence weight two knot reads, the serial divider (skipped when no division is
// needed), multiply and accumulate, then a read, multiply and output per result
// one item at a time; the serial divider and the single knot read port set the rate
// reset: degree 3, num_knots 8; knot and coefficient tables undefined until written
`default_nettype none
module bspline_basis_evaluator (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire bsb_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output bsb_pkg::rsp_type      rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic             csr_index,
   input  wire logic [6:0]       csr_wdata
);
   import bsb_pkg::*;

   state_type state_ff, state_in;

   logic [2:0]  degree_ff;
   logic [6:0]  num_knots_ff;
   logic [6:0]  n_eff;

   logic [31:0] knot_mem  [MAX_KNOTS];
   logic [31:0] coeff_mem [MAX_KNOTS];
   logic [16:0] basis_mem [BASIS_DEPTH];
   logic signed [31:0] knot_q_ff, coeff_q_ff;
   logic [16:0] basis_q_ff;
   logic [KNOT_AW-1:0]  knot_raddr, coeff_raddr;
   logic [BASIS_AW-1:0] basis_raddr, basis_waddr;
   logic        basis_we;
   logic [16:0] basis_wdata;

   logic signed [8:0]  mu_ff, mu_in;
   logic [6:0]  s_ff, s_in;
   logic [2:0]  k_ff, k_in, i_ff, i_in, j_ff, j_in;
   logic signed [31:0] x_ff, x_in, tl_ff, tl_in;
   logic [16:0] b_ff, b_in, wr_ff, wr_in, wl_ff, wl_in, bv_ff, bv_in;
   logic [33:0] pl_ff, pl_in, pr_ff, pr_in, carry_ff, carry_in;
   logic signed [49:0] prod_ff, prod_in;
   logic signed [52:0] acc_ff, acc_in, sum;
   logic signed [36:0] rnd;
   logic signed [31:0] sat;

   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;
   logic        out_free, accept, rsp_load;

   logic        do_div, div_done;
   logic [15:0] div_q;
   logic [32:0] div_num, div_den;
   logic signed [8:0] gi_full, tl_idx, tr_idx;
   logic        found;

   assign csr_ready = 1'b1;
   assign n_eff     = (num_knots_ff < 7'd2) ? 7'd2 :
                      (num_knots_ff > 7'(MAX_KNOTS)) ? 7'(MAX_KNOTS) : num_knots_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !out_free;
   assign accept    = req_valid && !req_stall;

   assign tl_idx  = mu_ff + $signed({6'b0, i_ff}) - $signed({6'b0, k_ff});
   assign tr_idx  = mu_ff + $signed({6'b0, i_ff});
   assign gi_full = mu_ff - $signed({6'b0, degree_ff}) - 9'sd1 + $signed({6'b0, j_ff});
   assign found   = knot_q_ff > x_ff;

   assign do_div  = (knot_q_ff > tl_ff) && (x_ff > tl_ff) && (x_ff < knot_q_ff);
   assign div_num = 33'($signed({x_ff[31], x_ff}) - $signed({tl_ff[31], tl_ff}));
   assign div_den = 33'($signed({knot_q_ff[31], knot_q_ff}) - $signed({tl_ff[31], tl_ff}));

   bsb_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    ((state_ff == ST_PREP) && do_div),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         degree_ff    <= 3'd3;
         num_knots_ff <= 7'd8;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DEGREE:    degree_ff    <= csr_wdata[2:0];
            CSR_NUM_KNOTS: num_knots_ff <= csr_wdata;
            default:       degree_ff    <= degree_ff;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_data.cmd == CMD_EVAL) state_in = ST_SRCH_RD;
         end
         ST_SRCH_RD:  state_in = ST_SRCH_CMP;
         ST_SRCH_CMP: begin
            if (found) state_in = (s_ff == 7'd0) ? ST_ERR : ST_INIT;
            else if (s_ff == n_eff - 7'd1) state_in = ST_INIT;
            else state_in = ST_SRCH_RD;
         end
         ST_ERR:  if (out_free) state_in = ST_IDLE;
         ST_INIT: state_in = (degree_ff == 3'd0) ? ST_DOT_RD : ST_TL;
         ST_TL:   state_in = ST_TR;
         ST_TR:   state_in = ST_PREP;
         ST_PREP: state_in = do_div ? ST_DIV : ST_MUL;
         ST_DIV:  if (div_done) state_in = ST_MUL;
         ST_MUL:  state_in = ST_ACC;
         ST_ACC:  state_in = (i_ff == k_ff - 3'd1) ? ST_LAST : ST_TL;
         ST_LAST: state_in = (k_ff == degree_ff) ? ST_DOT_RD : ST_TL;
         ST_DOT_RD:  state_in = ST_DOT_MUL;
         ST_DOT_MUL: state_in = ST_DOT_OUT;
         ST_DOT_OUT: begin
            if (out_free) state_in = (j_ff == degree_ff) ? ST_IDLE : ST_DOT_RD;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      mu_in = mu_ff;  s_in = s_ff;  k_in = k_ff;  i_in = i_ff;  j_in = j_ff;
      x_in = x_ff;  tl_in = tl_ff;  b_in = b_ff;  wr_in = wr_ff;  wl_in = wl_ff;
      bv_in = bv_ff;  pl_in = pl_ff;  pr_in = pr_ff;  carry_in = carry_ff;
      prod_in = prod_ff;  acc_in = acc_ff;
      knot_raddr  = s_ff[KNOT_AW-1:0];
      coeff_raddr = gi_full[KNOT_AW-1:0];
      basis_raddr = BASIS_AW'(i_ff);
      basis_we    = 1'b0;
      basis_waddr = BASIS_AW'(i_ff);
      basis_wdata = ONE_Q16;
      rsp_load    = 1'b0;
      rsp_data_in = rsp_data_ff;
      sum = acc_ff + 53'(prod_ff);
      rnd = 37'((sum + 53'sd32768) >>> 16);
      if (rnd > 37'sh7fffffff) sat = 32'sh7fffffff;
      else if (rnd < -37'sh80000000) sat = 32'sh80000000;
      else sat = rnd[31:0];
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               x_in = req_data.x_value;
               s_in = '0;
               if (req_data.cmd == CMD_WR_KNOT || req_data.cmd == CMD_WR_COEFF) begin
                  rsp_load    = 1'b1;
                  rsp_data_in = '{basis_index: req_data.table_index, basis_value: '0,
                                  spline_value: '0, status: STATUS_ACK, last: 1'b1};
               end
            end
         end
         ST_SRCH_CMP: begin
            s_in = s_ff + 7'd1;
            if (found) mu_in = $signed({2'b0, s_ff});
            else mu_in = $signed({2'b0, n_eff}) - $signed({6'b0, degree_ff}) - 9'sd1;
         end
         ST_ERR: begin
            if (out_free) begin
               rsp_load    = 1'b1;
               rsp_data_in = '{basis_index: '0, basis_value: '0, spline_value: '0,
                               status: STATUS_BELOW, last: 1'b1};
            end
         end
         ST_INIT: begin
            basis_we    = 1'b1;
            basis_waddr = '0;
            basis_wdata = ONE_Q16;
            k_in = 3'd1;  i_in = '0;  j_in = '0;
            carry_in = '0;  acc_in = '0;
         end
         ST_TL: knot_raddr = knot_idx(tl_idx, n_eff);
         ST_TR: begin
            knot_raddr = knot_idx(tr_idx, n_eff);
            tl_in = knot_q_ff;
         end
         ST_PREP: begin
            b_in = basis_q_ff;
            if (knot_q_ff <= tl_ff) begin
               wr_in = '0;  wl_in = '0;
            end else if (x_ff <= tl_ff) begin
               wr_in = '0;  wl_in = ONE_Q16;
            end else if (x_ff >= knot_q_ff) begin
               wr_in = ONE_Q16;  wl_in = '0;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               wr_in = {1'b0, div_q};
               wl_in = ONE_Q16 - {1'b0, div_q};
            end
         end
         ST_MUL: begin
            pl_in = wl_ff * b_ff;
            pr_in = wr_ff * b_ff;
         end
         ST_ACC: begin
            basis_we    = 1'b1;
            basis_wdata = clamp_q16({1'b0, pl_ff} + {1'b0, carry_ff});
            carry_in    = pr_ff;
            if (i_ff != k_ff - 3'd1) i_in = i_ff + 3'd1;
         end
         ST_LAST: begin
            basis_we    = 1'b1;
            basis_waddr = BASIS_AW'(k_ff);
            basis_wdata = clamp_q16({1'b0, carry_ff});
            k_in = k_ff + 3'd1;  i_in = '0;  carry_in = '0;
         end
         ST_DOT_RD: basis_raddr = BASIS_AW'(j_ff);
         ST_DOT_MUL: begin
            prod_in = $signed({1'b0, basis_q_ff}) * coeff_q_ff;
            bv_in   = basis_q_ff;
         end
         ST_DOT_OUT: begin
            if (out_free) begin
               acc_in   = sum;
               j_in     = j_ff + 3'd1;
               rsp_load = 1'b1;
               rsp_data_in = '{basis_index: gi_full[5:0], basis_value: bv_ff,
                               spline_value: (j_ff == degree_ff) ? sat : 32'sd0,
                               status: STATUS_OK, last: (j_ff == degree_ff)};
            end
         end
         default: rsp_load = 1'b0;
      endcase
      if (rsp_load) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (accept && req_data.cmd == CMD_WR_KNOT)
         knot_mem[req_data.table_index] <= req_data.write_value;
      if (accept && req_data.cmd == CMD_WR_COEFF)
         coeff_mem[req_data.table_index] <= req_data.write_value;
      if (basis_we) basis_mem[basis_waddr] <= basis_wdata;
      knot_q_ff  <= knot_mem[knot_raddr];
      coeff_q_ff <= coeff_mem[coeff_raddr];
      basis_q_ff <= basis_mem[basis_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mu_ff <= mu_in;  s_ff <= s_in;  k_ff <= k_in;  i_ff <= i_in;  j_ff <= j_in;
      x_ff <= x_in;  tl_ff <= tl_in;  b_ff <= b_in;  wr_ff <= wr_in;  wl_ff <= wl_in;
      bv_ff <= bv_in;  pl_ff <= pl_in;  pr_ff <= pr_in;  carry_ff <= carry_in;
      prod_ff <= prod_in;  acc_ff <= acc_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV) else $error("divider done outside divide state");
   a_ack_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STATUS_ACK |-> rsp_data.last)
      else $error("write acknowledge without last");
   a_mid_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |-> rsp_data.status == STATUS_OK &&
      rsp_data.spline_value == 32'sd0) else $error("bad intermediate result");
   a_basis_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.basis_value <= ONE_Q16) else $error("basis value above one");
`endif

endmodule
`default_nettype wire

>>> src/bsb_div.sv
`default_nettype none
module bsb_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [32:0] dividend,
   input  wire logic [32:0] divisor,
   output logic             done,
   output logic [15:0]      quotient
);
   import bsb_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [32:0] rem_ff, rem_in;
   logic [32:0] den_ff, den_in;
   logic [15:0] q_ff, q_in;
   logic [33:0] shifted;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      shifted = {rem_ff, 1'b0};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = dividend;
         den_in  = divisor;
         q_in    = '0;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, den_ff}) begin
            rem_in = 33'(shifted - {1'b0, den_ff});
            q_in   = {q_ff[14:0], 1'b1};
         end else begin
            rem_in = shifted[32:0];
            q_in   = {q_ff[14:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff   <= q_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule
`default_nettype wire
